FILE: design/imh_pkg.sv
// shared types and constants for the indexed min-heap
// no dependencies
`timescale 1ns / 1ps

package imh_pkg;

	localparam int KEY_BITS   = 10;
	localparam int PRI_BITS   = 32;
	localparam int POS_BITS   = 10;
	localparam int COUNT_BITS = 11;
	localparam int DEPTH      = 1 << POS_BITS;
	localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(DEPTH);

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_UPDATE = 2'd1,
		OP_POP    = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_REFUSED = 2'd2,
		ST_ABSENT  = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]          operation;
		logic [KEY_BITS-1:0] item_key;
		logic [PRI_BITS-1:0] item_priority;
	} item_t;

	typedef struct packed {
		logic [KEY_BITS-1:0]   out_key;
		logic [PRI_BITS-1:0]   out_priority;
		logic [1:0]            status;
		logic [COUNT_BITS-1:0] entry_count;
	} result_t;

	// one heap slot: key and its priority
	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [PRI_BITS-1:0] pri;
	} slot_t;

	// key map entry: present flag and heap position
	typedef struct packed {
		logic                present;
		logic [POS_BITS-1:0] pos;
	} map_t;

endpackage

FILE: design/indexed_min_heap.sv
// indexed binary min-heap top level: sequencer, heap slot memory, key map memory
// depends on imh_pkg
`timescale 1ns / 1ps

// Indexed min-heap of up to 1024 keys with 32-bit unsigned priorities. Push adds a key,
// update changes the priority of a present key (sift up, then sift down), pop removes the
// key of smallest priority and returns it. One transfer is taken at a time; item_ready
// stays low until the operation is finished. An operation takes longer for each level
// that it climbs or descends; the single read port of the heap slot memory sets this.
// After reset the key map is cleared in a pass over all 1024 entries during which no
// item is taken. The result register lets the next item enter while a result waits
// for result_ready.
module indexed_min_heap
	import imh_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_LOOK, S_LAST, S_UP, S_UPCMP, S_DN, S_DNL, S_DNR, S_FIN, S_RES
	} state_t;

	state_t                state_q;
	logic [POS_BITS-1:0]   clr_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [1:0]            op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [PRI_BITS-1:0]   pri_q;
	slot_t                 cur_q;
	slot_t                 left_q;
	logic [POS_BITS-1:0]   pos_q;
	logic [KEY_BITS-1:0]   rkey_q;
	logic [PRI_BITS-1:0]   rpri_q;
	logic [1:0]            rstat_q;
	logic                  result_valid_q;
	result_t               result_q;

	// memories
	slot_t heap_mem [DEPTH];
	map_t  map_mem [DEPTH];
	slot_t heap_rd_q;
	map_t  map_rd_q;

	logic                heap_we, map_we;
	logic [POS_BITS-1:0] heap_waddr, heap_raddr;
	slot_t               heap_wdata;
	logic [KEY_BITS-1:0] map_waddr, map_raddr;
	map_t                map_wdata;

	// tree addressing
	logic [COUNT_BITS-1:0] left_idx, right_idx, last_idx;
	logic [POS_BITS-1:0]   parent_pos;
	logic                  pick_l, pick_r, dn_move;
	logic [PRI_BITS-1:0]   best_pri;
	slot_t                 dn_ent;
	logic [POS_BITS-1:0]   dn_pos;
	logic                  item_xfer, out_free;

	assign left_idx   = {pos_q, 1'b1};
	assign right_idx  = {pos_q, 1'b1} + COUNT_BITS'(1);
	assign last_idx   = count_q - COUNT_BITS'(1);
	assign parent_pos = (pos_q - POS_BITS'(1)) >> 1;
	assign item_ready = (state_q == S_IDLE);
	assign item_xfer  = item_valid && item_ready;
	assign out_free   = !result_valid_q || result_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// child choice for sift-down: left first, right only if strictly smaller still
	always_comb begin
		if (state_q == S_DNL) begin
			pick_l = heap_rd_q.pri < cur_q.pri;
			pick_r = 1'b0;
			best_pri = cur_q.pri;
			dn_ent = heap_rd_q;
			dn_pos = left_idx[POS_BITS-1:0];
		end else begin
			pick_l = left_q.pri < cur_q.pri;
			best_pri = pick_l ? left_q.pri : cur_q.pri;
			pick_r = heap_rd_q.pri < best_pri;
			dn_ent = pick_r ? heap_rd_q : left_q;
			dn_pos = pick_r ? right_idx[POS_BITS-1:0] : left_idx[POS_BITS-1:0];
		end
		dn_move = pick_l || pick_r;
	end

	// memory port control
	always_comb begin
		heap_we    = 1'b0;
		heap_waddr = pos_q;
		heap_wdata = dn_ent;
		heap_raddr = '0;
		map_we     = 1'b0;
		map_waddr  = dn_ent.key;
		map_wdata  = '{present: 1'b1, pos: pos_q};
		map_raddr  = item.item_key;
		case (state_q)
			S_CLR: begin
				map_we    = 1'b1;
				map_waddr = clr_q;
				map_wdata = '0;
			end
			S_LOOK: begin
				heap_raddr = last_idx[POS_BITS-1:0];
				if (!(op_q inside {OP_PUSH, OP_UPDATE}) && count_q != '0) begin
					map_we    = 1'b1;
					map_waddr = heap_rd_q.key;
					map_wdata = '0;
				end
			end
			S_UP: heap_raddr = parent_pos;
			S_UPCMP: begin
				if (heap_rd_q.pri > cur_q.pri) begin
					heap_we    = 1'b1;
					heap_wdata = heap_rd_q;
					map_we     = 1'b1;
					map_waddr  = heap_rd_q.key;
				end
			end
			S_DN: heap_raddr = left_idx[POS_BITS-1:0];
			S_DNL: begin
				heap_raddr = right_idx[POS_BITS-1:0];
				if (right_idx >= count_q && dn_move) begin
					heap_we = 1'b1;
					map_we  = 1'b1;
				end
			end
			S_DNR: begin
				if (dn_move) begin
					heap_we = 1'b1;
					map_we  = 1'b1;
				end
			end
			S_FIN: begin
				heap_we    = 1'b1;
				heap_wdata = cur_q;
				map_we     = 1'b1;
				map_waddr  = cur_q.key;
			end
			default: ;
		endcase
	end

	// heap slot memory
	always_ff @(posedge clk) begin
		if (heap_we) begin
			heap_mem[heap_waddr] <= heap_wdata;
		end
		heap_rd_q <= heap_mem[heap_raddr];
	end

	// key map memory
	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_waddr] <= map_wdata;
		end
		map_rd_q <= map_mem[map_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLR;
			clr_q          <= '0;
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && result_ready && state_q != S_RES) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + POS_BITS'(1);
					if (clr_q == POS_BITS'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item_xfer) begin
						op_q    <= item.operation;
						key_q   <= item.item_key;
						pri_q   <= item.item_priority;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					rkey_q  <= key_q;
					rpri_q  <= '0;
					rstat_q <= ST_OK;
					cur_q   <= '{key: key_q, pri: pri_q};
					case (op_q)
						OP_PUSH: begin
							if (map_rd_q.present || count_q >= FULL_COUNT) begin
								rstat_q <= ST_REFUSED;
								state_q <= S_RES;
							end else begin
								pos_q   <= count_q[POS_BITS-1:0];
								count_q <= count_q + COUNT_BITS'(1);
								state_q <= S_UP;
							end
						end
						OP_UPDATE: begin
							if (!map_rd_q.present) begin
								rstat_q <= ST_ABSENT;
								state_q <= S_RES;
							end else begin
								pos_q   <= map_rd_q.pos;
								state_q <= S_UP;
							end
						end
						default: begin
							if (count_q == '0) begin
								rstat_q <= ST_EMPTY;
								rkey_q  <= '0;
								state_q <= S_RES;
							end else begin
								rkey_q  <= heap_rd_q.key;
								rpri_q  <= heap_rd_q.pri;
								count_q <= last_idx;
								pos_q   <= '0;
								state_q <= (last_idx == '0) ? S_RES : S_LAST;
							end
						end
					endcase
				end
				S_LAST: begin
					cur_q   <= heap_rd_q;
					state_q <= S_DN;
				end
				S_UP: begin
					state_q <= (pos_q == '0) ? S_DN : S_UPCMP;
				end
				S_UPCMP: begin
					if (heap_rd_q.pri > cur_q.pri) begin
						pos_q   <= parent_pos;
						state_q <= S_UP;
					end else begin
						state_q <= S_DN;
					end
				end
				S_DN: begin
					state_q <= (left_idx >= count_q) ? S_FIN : S_DNL;
				end
				S_DNL: begin
					left_q <= heap_rd_q;
					if (right_idx < count_q) begin
						state_q <= S_DNR;
					end else if (dn_move) begin
						pos_q   <= dn_pos;
						state_q <= S_DN;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_DNR: begin
					if (dn_move) begin
						pos_q   <= dn_pos;
						state_q <= S_DN;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: state_q <= S_RES;
				S_RES: begin
					if (out_free) begin
						result_q       <= '{out_key: rkey_q, out_priority: rpri_q,
							status: rstat_q, entry_count: count_q};
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: bench/tb_indexed_min_heap.sv
// self-checking bench for the indexed min-heap: random push, update and pop traffic
// checked transfer by transfer against a behavioral heap model; depends on imh_pkg
`timescale 1ns / 1ps

module tb_indexed_min_heap;
	import imh_pkg::*;

	localparam int HEAP_CAP = 1024;
	localparam int FILL_KEYS = 120;
	// spare operation code, handled as a pop
	localparam logic [1:0] OP_SPARE = 2'd3;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	indexed_min_heap dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always #1 clk = ~clk;

	// behavioral heap state
	logic [KEY_BITS-1:0] slot_key [HEAP_CAP];
	logic [COUNT_BITS-1:0] key_pos [HEAP_CAP];
	logic key_held [HEAP_CAP];
	logic [PRI_BITS-1:0] key_pri [HEAP_CAP];
	int unsigned n_held = 0;

	item_t   pending_items[$];
	result_t expected_results[$];
	bit      failed = 0;
	bit      stim_done = 0;

	function automatic logic [PRI_BITS-1:0] pri_of(int unsigned p);
		return key_pri[slot_key[p]];
	endfunction

	function automatic void swap_slots(int unsigned a, int unsigned b);
		logic [KEY_BITS-1:0] ka, kb;
		ka = slot_key[a];
		kb = slot_key[b];
		slot_key[a] = kb;
		slot_key[b] = ka;
		key_pos[kb] = COUNT_BITS'(a);
		key_pos[ka] = COUNT_BITS'(b);
	endfunction

	function automatic void bubble_up(int unsigned p);
		int unsigned par;
		while (p > 0) begin
			par = (p - 1) / 2;
			if (pri_of(par) <= pri_of(p))
				break;
			swap_slots(par, p);
			p = par;
		end
	endfunction

	function automatic void bubble_down(int unsigned p);
		int unsigned l, r, best;
		forever begin
			l = 2 * p + 1;
			r = l + 1;
			best = p;
			if (l < n_held && pri_of(l) < pri_of(best))
				best = l;
			if (r < n_held && pri_of(r) < pri_of(best))
				best = r;
			if (best == p)
				break;
			swap_slots(p, best);
			p = best;
		end
	endfunction

	// apply one operation to the heap model and return its result
	function automatic result_t heap_apply(item_t it);
		result_t r;
		logic [KEY_BITS-1:0] k, top;
		r.out_key = it.item_key;
		r.out_priority = '0;
		r.status = ST_OK;
		k = it.item_key;
		if (it.operation == OP_PUSH) begin
			if (key_held[k] || n_held >= HEAP_CAP) begin
				r.status = ST_REFUSED;
			end else begin
				slot_key[n_held] = k;
				key_pos[k] = COUNT_BITS'(n_held);
				key_held[k] = 1'b1;
				key_pri[k] = it.item_priority;
				n_held++;
				bubble_up(n_held - 1);
			end
		end else if (it.operation == OP_UPDATE) begin
			if (!key_held[k]) begin
				r.status = ST_ABSENT;
			end else begin
				key_pri[k] = it.item_priority;
				bubble_up(int'(key_pos[k]));
				bubble_down(int'(key_pos[k]));
			end
		end else begin
			if (n_held == 0) begin
				r.status = ST_EMPTY;
				r.out_key = '0;
			end else begin
				top = slot_key[0];
				r.out_key = top;
				r.out_priority = key_pri[top];
				swap_slots(0, n_held - 1);
				key_held[top] = 1'b0;
				n_held--;
				if (n_held > 0)
					bubble_down(0);
			end
		end
		r.entry_count = COUNT_BITS'(n_held);
		return r;
	endfunction

	function automatic item_t mk(logic [1:0] op, int unsigned k, logic [31:0] p);
		item_t it;
		it.operation = op;
		it.item_key = KEY_BITS'(k);
		it.item_priority = p;
		return it;
	endfunction

	// stimulus: directed corners, a fill and drain, then random traffic
	initial begin
		int unsigned kp, lim, nk, x;
		logic [1:0] op;
		for (int i = 0; i < HEAP_CAP; i++)
			key_held[i] = 1'b0;
		pending_items.push_back(mk(OP_POP, 0, 0));
		pending_items.push_back(mk(OP_UPDATE, 5, 32'h1234));
		pending_items.push_back(mk(OP_PUSH, 1023, 32'hFFFF_FFFF));
		pending_items.push_back(mk(OP_PUSH, 0, 32'h0));
		pending_items.push_back(mk(OP_PUSH, 0, 32'h5));
		pending_items.push_back(mk(OP_PUSH, 512, 32'h8000_0000));
		pending_items.push_back(mk(OP_PUSH, 341, 32'h8000_0000));
		pending_items.push_back(mk(OP_UPDATE, 0, 32'hFFFF_FFFF));
		pending_items.push_back(mk(OP_UPDATE, 1023, 32'h0));
		pending_items.push_back(mk(OP_SPARE, 682, 32'h5555_5555));
		pending_items.push_back(mk(OP_POP, 0, 0));
		pending_items.push_back(mk(OP_POP, 0, 0));
		pending_items.push_back(mk(OP_POP, 0, 0));
		pending_items.push_back(mk(OP_POP, 0, 0));
		pending_items.push_back(mk(OP_PUSH, 7, 32'hAAAA_AAAA));
		pending_items.push_back(mk(OP_UPDATE, 7, 32'h5555_5555));
		pending_items.push_back(mk(OP_POP, 0, 0));
		// fill with distinct keys, then a refused duplicate push and random updates, then drain
		for (int i = 0; i < FILL_KEYS; i++)
			pending_items.push_back(mk(OP_PUSH, i, $urandom_range(0, 255)));
		pending_items.push_back(mk(OP_PUSH, 3, 32'h1));
		for (int i = 0; i < 20; i++)
			pending_items.push_back(mk(OP_UPDATE, $urandom_range(0, FILL_KEYS - 1),
				$urandom));
		for (int i = 0; i < FILL_KEYS; i++)
			pending_items.push_back(mk(OP_POP, 0, 0));
		// random traffic over a narrow key range so updates and duplicates hit
		for (int i = 0; i < 470; i++) begin
			x = $urandom_range(0, 99);
			op = (x < 45) ? OP_PUSH : (x < 70) ? OP_UPDATE : (x < 97) ? OP_POP : OP_SPARE;
			nk = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
				: $urandom_range(0, 47);
			kp = $urandom;
			lim = $urandom_range(0, 2);
			if (lim == 0)
				kp = kp & 32'hF;
			pending_items.push_back(mk(op, nk, kp));
		end
		stim_done = 1;
	end

	// driver: bursts of transfers separated by random gaps
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) begin
				expected_results.push_back(heap_apply(item));
			end
			if (!item_valid || item_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					item_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					item <= pending_items.pop_front();
					item_valid <= 1'b1;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result transfer, receiver stalls in its own pattern
	int unsigned stall_phase = 0;
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result key=%0d", result.out_key);
					failed = 1;
				end else begin
					exp_r = expected_results.pop_front();
					if (result.out_key !== exp_r.out_key) begin
						$error("out_key exp %0d got %0d", exp_r.out_key, result.out_key);
						failed = 1;
					end
					if (result.out_priority !== exp_r.out_priority) begin
						$error("out_priority exp %h got %h", exp_r.out_priority,
							result.out_priority);
						failed = 1;
					end
					if (result.status !== exp_r.status) begin
						$error("status exp %0d got %0d", exp_r.status, result.status);
						failed = 1;
					end
					if (result.entry_count !== exp_r.entry_count) begin
						$error("entry_count exp %0d got %0d", exp_r.entry_count,
							result.entry_count);
						failed = 1;
					end
				end
			end
			stall_phase <= stall_phase + 1;
			if (stall_phase[9])
				result_ready <= 1'b1;
			else if (stall_phase[4:0] < 8)
				result_ready <= ($urandom_range(0, 3) == 0);
			else
				result_ready <= ($urandom_range(0, 4) != 0);
		end
	end

	// reset, then wait for drain
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done);
		@(posedge clk);
		while (pending_items.size() > 0 || item_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (!failed && expected_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// overall time limit
	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule

FILE: indexed_min_heap.f
design/imh_pkg.sv
design/indexed_min_heap.sv
bench/tb_indexed_min_heap.sv
